FILE: design/wac_pkg.sv
// shared constants, types and codes of the windowed average alert classifier
`default_nettype none

package wac_pkg;

    // window and field widths
    localparam int WINDOW_DEPTH = 300;
    localparam int HRV_W        = 16;
    localparam int TEMP_W       = 14;
    localparam int ALERT_W      = 2;
    localparam int SLOT_W       = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int COUNT_W      = $clog2(WINDOW_DEPTH + 1);
    localparam int HRV_TOTAL_W  = HRV_W + COUNT_W;
    localparam int TEMP_TOTAL_W = TEMP_W + COUNT_W;

    // divider: quotient is at most one sample wide
    localparam int QUOT_W       = HRV_W;
    localparam int DIVIDEND_W   = QUOT_W + COUNT_W;
    localparam int STEP_W       = $clog2(QUOT_W + 1);

    // configuration port
    localparam int CFG_INDEX_W  = 8;
    localparam int CFG_DATA_W   = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_HRV_CRITICAL  = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_HRV_WARNING   = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_TEMP_CRITICAL = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_TEMP_WARNING  = 8'd3;

    localparam logic [HRV_W-1:0]  HRV_CRITICAL_RESET  = 16'd500;
    localparam logic [HRV_W-1:0]  HRV_WARNING_RESET   = 16'd600;
    localparam logic [TEMP_W-1:0] TEMP_CRITICAL_RESET = 14'd3600;
    localparam logic [TEMP_W-1:0] TEMP_WARNING_RESET  = 14'd3650;

    // alert levels
    localparam logic [ALERT_W-1:0] ALERT_OPTIMAL   = 2'd0;
    localparam logic [ALERT_W-1:0] ALERT_ATTENTION = 2'd1;
    localparam logic [ALERT_W-1:0] ALERT_CRITICAL  = 2'd2;

    // sequencer states
    typedef enum logic [6:0] {
        ST_IDLE      = 7'b0000001,
        ST_UPDATE    = 7'b0000010,
        ST_HRV_GO    = 7'b0000100,
        ST_HRV_WAIT  = 7'b0001000,
        ST_TEMP_GO   = 7'b0010000,
        ST_TEMP_WAIT = 7'b0100000,
        ST_FINISH    = 7'b1000000
    } state_t;

    // divider status toward the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

`default_nettype wire

FILE: design/wac_channels.sv
// valid/ready channel interfaces for samples, results and configuration
`default_nettype none

interface wac_sample_if;
    logic                      valid;
    logic                      ready;
    logic [wac_pkg::HRV_W-1:0]  hrv_sample;
    logic [wac_pkg::TEMP_W-1:0] temp_sample;

    modport source (output valid, output hrv_sample, output temp_sample, input ready);
    modport sink (input valid, input hrv_sample, input temp_sample, output ready);
endinterface

interface wac_result_if;
    logic                        valid;
    logic                        ready;
    logic [wac_pkg::HRV_W-1:0]   hrv_average;
    logic [wac_pkg::TEMP_W-1:0]  temp_average;
    logic [wac_pkg::ALERT_W-1:0] alert_level;

    modport source (output valid, output hrv_average, output temp_average,
                    output alert_level, input ready);
    modport sink (input valid, input hrv_average, input temp_average,
                  input alert_level, output ready);
endinterface

interface wac_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [wac_pkg::CFG_INDEX_W-1:0] index;
    logic [wac_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: design/windowed_average_alert_classifier.sv
// The single shared divider runs 16 steps for the hrv mean and 16 more for the temperature
// mean; a new sample is taken only once the sequencer is back in idle.
// The output register lets a new sample enter while the last result waits.
// Reset: asynchronous active-low; clears the window count, slot, totals and limits
// (500, 600, 3600, 3650); the sample stores themselves are not cleared.
`default_nettype none

module windowed_average_alert_classifier (
    input  wire logic      clk,
    input  wire logic      rst_n,
    wac_sample_if.sink     samples,
    wac_result_if.source   results,
    wac_cfg_if.sink        cfg
);

    wac_pkg::state_t state_reg;
    wac_pkg::state_t state_next;

    logic [wac_pkg::HRV_W-1:0]        hrv_crit_reg;
    logic [wac_pkg::HRV_W-1:0]        hrv_warn_reg;
    logic [wac_pkg::TEMP_W-1:0]       temp_crit_reg;
    logic [wac_pkg::TEMP_W-1:0]       temp_warn_reg;

    logic [wac_pkg::SLOT_W-1:0]       slot_reg;
    logic [wac_pkg::SLOT_W-1:0]       slot_next;
    logic [wac_pkg::COUNT_W-1:0]      count_reg;
    logic [wac_pkg::COUNT_W-1:0]      count_next;
    logic [wac_pkg::HRV_TOTAL_W-1:0]  hrv_total_reg;
    logic [wac_pkg::HRV_TOTAL_W-1:0]  hrv_total_next;
    logic [wac_pkg::TEMP_TOTAL_W-1:0] temp_total_reg;
    logic [wac_pkg::TEMP_TOTAL_W-1:0] temp_total_next;

    logic [wac_pkg::HRV_W-1:0]        hrv_smp_reg;
    logic [wac_pkg::TEMP_W-1:0]       temp_smp_reg;
    logic [wac_pkg::HRV_W-1:0]        hrv_avg_reg;
    logic [wac_pkg::TEMP_W-1:0]       temp_avg_reg;

    logic                             out_valid_reg;
    logic                             out_valid_next;
    logic [wac_pkg::HRV_W-1:0]        out_hrv_reg;
    logic [wac_pkg::TEMP_W-1:0]       out_temp_reg;
    logic [wac_pkg::ALERT_W-1:0]      out_alert_reg;
    logic [wac_pkg::ALERT_W-1:0]      alert;

    logic                             in_xfer;
    logic                             out_xfer;
    logic                             out_free;
    logic                             full;
    logic [wac_pkg::HRV_W-1:0]        hrv_old;
    logic [wac_pkg::TEMP_W-1:0]       temp_old;
    logic                             store_wr;

    logic                             div_start;
    logic [wac_pkg::DIVIDEND_W-1:0]   div_dividend;
    logic [wac_pkg::QUOT_W-1:0]       div_quot;
    wac_pkg::div_status_t             div_stat;

    // handshakes
    assign samples.ready = (state_reg == wac_pkg::ST_IDLE);
    assign in_xfer       = samples.valid && samples.ready;
    assign out_xfer      = out_valid_reg && results.ready;
    assign out_free      = !out_valid_reg || results.ready;
    assign cfg.ready     = 1'b1;

    // sample windows: old entry read on transfer, new entry written in update
    assign store_wr = (state_reg == wac_pkg::ST_UPDATE);

    wac_ram #(
        .WIDTH (wac_pkg::HRV_W),
        .DEPTH (wac_pkg::WINDOW_DEPTH)
    ) u_hrv_store (
        .clk     (clk),
        .wr_en   (store_wr),
        .wr_addr (slot_reg),
        .wr_data (hrv_smp_reg),
        .rd_en   (in_xfer),
        .rd_addr (slot_reg),
        .rd_data (hrv_old)
    );

    wac_ram #(
        .WIDTH (wac_pkg::TEMP_W),
        .DEPTH (wac_pkg::WINDOW_DEPTH)
    ) u_temp_store (
        .clk     (clk),
        .wr_en   (store_wr),
        .wr_addr (slot_reg),
        .wr_data (temp_smp_reg),
        .rd_en   (in_xfer),
        .rd_addr (slot_reg),
        .rd_data (temp_old)
    );

    // running totals, fill count and write slot
    assign full = (count_reg == wac_pkg::COUNT_W'(wac_pkg::WINDOW_DEPTH));

    always_comb
    begin
        slot_next       = slot_reg;
        count_next      = count_reg;
        hrv_total_next  = hrv_total_reg;
        temp_total_next = temp_total_reg;
        if (store_wr)
        begin
            hrv_total_next  = hrv_total_reg + wac_pkg::HRV_TOTAL_W'(hrv_smp_reg)
                            - (full ? wac_pkg::HRV_TOTAL_W'(hrv_old) : '0);
            temp_total_next = temp_total_reg + wac_pkg::TEMP_TOTAL_W'(temp_smp_reg)
                            - (full ? wac_pkg::TEMP_TOTAL_W'(temp_old) : '0);
            if (!full)
            begin
                count_next = count_reg + 1'b1;
            end
            if (slot_reg == wac_pkg::SLOT_W'(wac_pkg::WINDOW_DEPTH - 1))
            begin
                slot_next = '0;
            end
            else
            begin
                slot_next = slot_reg + 1'b1;
            end
        end
    end

    // shared divider, hrv total first then temperature total
    assign div_start    = (state_reg == wac_pkg::ST_HRV_GO) ||
                          (state_reg == wac_pkg::ST_TEMP_GO);
    assign div_dividend = (state_reg == wac_pkg::ST_HRV_GO)
                        ? wac_pkg::DIVIDEND_W'(hrv_total_reg)
                        : wac_pkg::DIVIDEND_W'(temp_total_reg);

    wac_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (count_reg),
        .status   (div_stat),
        .quotient (div_quot)
    );

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            wac_pkg::ST_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = wac_pkg::ST_UPDATE;
                end
            end
            wac_pkg::ST_UPDATE:    state_next = wac_pkg::ST_HRV_GO;
            wac_pkg::ST_HRV_GO:    state_next = wac_pkg::ST_HRV_WAIT;
            wac_pkg::ST_HRV_WAIT:
            begin
                if (div_stat.done)
                begin
                    state_next = wac_pkg::ST_TEMP_GO;
                end
            end
            wac_pkg::ST_TEMP_GO:   state_next = wac_pkg::ST_TEMP_WAIT;
            wac_pkg::ST_TEMP_WAIT:
            begin
                if (div_stat.done)
                begin
                    state_next = wac_pkg::ST_FINISH;
                end
            end
            wac_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = wac_pkg::ST_IDLE;
                end
            end
            default:               state_next = wac_pkg::ST_IDLE;
        endcase
    end

    // alert level from the two means
    always_comb
    begin
        if ((hrv_avg_reg < hrv_crit_reg) || (temp_avg_reg < temp_crit_reg))
        begin
            alert = wac_pkg::ALERT_CRITICAL;
        end
        else if ((hrv_avg_reg < hrv_warn_reg) || (temp_avg_reg < temp_warn_reg))
        begin
            alert = wac_pkg::ALERT_ATTENTION;
        end
        else
        begin
            alert = wac_pkg::ALERT_OPTIMAL;
        end
    end

    // output register valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_xfer)
        begin
            out_valid_next = 1'b0;
        end
        if ((state_reg == wac_pkg::ST_FINISH) && out_free)
        begin
            out_valid_next = 1'b1;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= wac_pkg::ST_IDLE;
            slot_reg       <= '0;
            count_reg      <= '0;
            hrv_total_reg  <= '0;
            temp_total_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            slot_reg       <= slot_next;
            count_reg      <= count_next;
            hrv_total_reg  <= hrv_total_next;
            temp_total_reg <= temp_total_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // limit registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hrv_crit_reg  <= wac_pkg::HRV_CRITICAL_RESET;
            hrv_warn_reg  <= wac_pkg::HRV_WARNING_RESET;
            temp_crit_reg <= wac_pkg::TEMP_CRITICAL_RESET;
            temp_warn_reg <= wac_pkg::TEMP_WARNING_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                wac_pkg::REG_HRV_CRITICAL:  hrv_crit_reg  <= cfg.data;
                wac_pkg::REG_HRV_WARNING:   hrv_warn_reg  <= cfg.data;
                wac_pkg::REG_TEMP_CRITICAL: temp_crit_reg <= cfg.data[wac_pkg::TEMP_W-1:0];
                wac_pkg::REG_TEMP_WARNING:  temp_warn_reg <= cfg.data[wac_pkg::TEMP_W-1:0];
                default:                    ;
            endcase
        end
    end

    // payload: latched samples, means and result
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            hrv_smp_reg  <= samples.hrv_sample;
            temp_smp_reg <= samples.temp_sample;
        end
        if ((state_reg == wac_pkg::ST_HRV_WAIT) && div_stat.done)
        begin
            hrv_avg_reg <= div_quot;
        end
        if ((state_reg == wac_pkg::ST_TEMP_WAIT) && div_stat.done)
        begin
            temp_avg_reg <= div_quot[wac_pkg::TEMP_W-1:0];
        end
        if ((state_reg == wac_pkg::ST_FINISH) && out_free)
        begin
            out_hrv_reg   <= hrv_avg_reg;
            out_temp_reg  <= temp_avg_reg;
            out_alert_reg <= alert;
        end
    end

    assign results.valid        = out_valid_reg;
    assign results.hrv_average  = out_hrv_reg;
    assign results.temp_average = out_temp_reg;
    assign results.alert_level  = out_alert_reg;

    // checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        int'(count_reg) <= wac_pkg::WINDOW_DEPTH)
        else $error("fill count beyond window depth");

    a_slot_bound: assert property (@(posedge clk) disable iff (!rst_n)
        int'(slot_reg) < wac_pkg::WINDOW_DEPTH)
        else $error("write slot beyond window depth");

    a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_stat.busy)
        else $error("divider started while busy");

    a_div_done_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> (state_reg == wac_pkg::ST_HRV_WAIT ||
                           state_reg == wac_pkg::ST_TEMP_WAIT))
        else $error("divider finished outside a wait state");

    a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == wac_pkg::ST_FINISH))
        else $error("result raised outside the finish state");

endmodule

`default_nettype wire

FILE: design/wac_ram.sv
// generic single-port-write, single-port-read ram with registered read data
`default_nettype none

module wac_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 300,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                  clk,
    input  wire logic                  wr_en,
    input  wire logic [ADDR_W-1:0]     wr_addr,
    input  wire logic [WIDTH-1:0]      wr_data,
    input  wire logic                  rd_en,
    input  wire logic [ADDR_W-1:0]     rd_addr,
    output logic      [WIDTH-1:0]      rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

FILE: design/wac_divider.sv
// shared restoring divider, one quotient bit per cycle
`default_nettype none

module wac_divider (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             start,
    input  wire logic [wac_pkg::DIVIDEND_W-1:0]   dividend,
    input  wire logic [wac_pkg::COUNT_W-1:0]      divisor,
    output wac_pkg::div_status_t                  status,
    output logic      [wac_pkg::QUOT_W-1:0]       quotient
);

    logic [wac_pkg::COUNT_W-1:0] rem_reg;
    logic [wac_pkg::COUNT_W-1:0] rem_next;
    logic [wac_pkg::QUOT_W-1:0]  work_reg;
    logic [wac_pkg::QUOT_W-1:0]  work_next;
    logic [wac_pkg::COUNT_W-1:0] divisor_reg;
    logic [wac_pkg::STEP_W-1:0]  step_reg;
    logic [wac_pkg::STEP_W-1:0]  step_next;
    logic                        busy_reg;
    logic                        busy_next;
    logic                        done_reg;
    logic                        done_next;
    logic [wac_pkg::COUNT_W:0]   trial;
    logic                        fits;

    // one restoring step: shift in the next dividend bit, subtract if it fits
    assign trial = {rem_reg, work_reg[wac_pkg::QUOT_W-1]};
    assign fits  = (trial >= {1'b0, divisor_reg});

    always_comb
    begin
        rem_next  = rem_reg;
        work_next = work_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            // the upper part is below the divisor since the mean fits in a sample
            rem_next  = dividend[wac_pkg::DIVIDEND_W-1:wac_pkg::QUOT_W];
            work_next = dividend[wac_pkg::QUOT_W-1:0];
            step_next = wac_pkg::STEP_W'(wac_pkg::QUOT_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next  = fits ? wac_pkg::COUNT_W'(trial - {1'b0, divisor_reg})
                             : trial[wac_pkg::COUNT_W-1:0];
            work_next = {work_reg[wac_pkg::QUOT_W-2:0], fits};
            step_next = step_reg - 1'b1;
            if (step_reg == wac_pkg::STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        work_reg <= work_next;
        if (start)
        begin
            divisor_reg <= divisor;
        end
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quotient    = work_reg;

endmodule

`default_nettype wire

FILE: test/tb_windowed_average_alert_classifier.sv
// self-checking testbench for the windowed average alert classifier with random stalls
module tb_windowed_average_alert_classifier;
    import wac_pkg::*;

    localparam int MAX_GAP      = 6;
    localparam int LONG_HOLD    = 500;
    localparam int STALL_LIMIT  = 4000;
    localparam int TAIL_CYCLES  = 80;
    localparam int REPORT_LIMIT = 200;
    localparam int HRV_TOP      = (1 << HRV_W) - 1;
    localparam int TEMP_TOP     = (1 << TEMP_W) - 1;

    // indexes past the last limit register, writes there change nothing
    localparam logic [CFG_INDEX_W-1:0] REG_FIRST_UNUSED = REG_TEMP_WARNING + 1'b1;
    localparam logic [CFG_INDEX_W-1:0] REG_LAST_UNUSED  = '1;

    typedef struct packed {
        logic [HRV_W-1:0]  hrv;
        logic [TEMP_W-1:0] temp;
    } vitals_t;

    typedef struct packed {
        logic [HRV_W-1:0]   hrv_avg;
        logic [TEMP_W-1:0]  temp_avg;
        logic [ALERT_W-1:0] level;
    } averages_t;

    logic clk = 1'b0;
    logic rst_n;

    wac_sample_if sample_ch ();
    wac_result_if result_ch ();
    wac_cfg_if    cfg_ch ();

    windowed_average_alert_classifier DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (sample_ch),
        .results (result_ch),
        .cfg     (cfg_ch)
    );

    // stimulus and expectations
    vitals_t   pending_vitals [$];
    averages_t expected_averages [$];
    vitals_t   staged;

    // window shadow and limit copies
    logic [HRV_W-1:0]  hrv_window [WINDOW_DEPTH];
    logic [TEMP_W-1:0] temp_window [WINDOW_DEPTH];
    int unsigned       write_pos;
    int unsigned       window_fill;
    int unsigned       hrv_sum;
    int unsigned       temp_sum;
    logic [HRV_W-1:0]  hrv_crit_lim;
    logic [HRV_W-1:0]  hrv_warn_lim;
    logic [TEMP_W-1:0] temp_crit_lim;
    logic [TEMP_W-1:0] temp_warn_lim;

    // flow control
    bit tx_gaps         = 1'b1;
    bit rx_gaps         = 1'b1;
    bit offering        = 1'b0;
    bit long_stall_go   = 1'b0;
    bit long_stall_done = 1'b0;
    int tx_wait         = 0;
    int rx_wait         = 0;
    int hold_left       = 0;
    int idle_cycles     = 0;

    // bookkeeping
    int error_count     = 0;
    int results_checked = 0;
    int register_writes = 0;
    int settings_used   = 1;
    int level_count [4] = '{default: 0};

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // shift one sample pair into the shadow window and queue its averages
    task automatic fold_into_window(input logic [HRV_W-1:0] hrv, input logic [TEMP_W-1:0] temp);
        averages_t   due;
        int unsigned hrv_mean;
        int unsigned temp_mean;
        if (window_fill >= WINDOW_DEPTH)
        begin
            hrv_sum  -= hrv_window[write_pos];
            temp_sum -= temp_window[write_pos];
        end
        else
        begin
            window_fill++;
        end
        hrv_window[write_pos]  = hrv;
        temp_window[write_pos] = temp;
        hrv_sum  += hrv;
        temp_sum += temp;
        write_pos = (write_pos + 1 >= WINDOW_DEPTH) ? 0 : write_pos + 1;
        hrv_mean     = hrv_sum / window_fill;
        temp_mean    = temp_sum / window_fill;
        due.hrv_avg  = HRV_W'(hrv_mean);
        due.temp_avg = TEMP_W'(temp_mean);
        if (hrv_mean < hrv_crit_lim || temp_mean < temp_crit_lim)
            due.level = ALERT_CRITICAL;
        else if (hrv_mean < hrv_warn_lim || temp_mean < temp_warn_lim)
            due.level = ALERT_ATTENTION;
        else
            due.level = ALERT_OPTIMAL;
        expected_averages.push_back(due);
    endtask

    // compare one result transfer with the oldest expectation
    task automatic check_averages(input averages_t got);
        averages_t due;
        if (expected_averages.size() == 0)
        begin
            error_count++;
            if (error_count <= REPORT_LIMIT)
                $display("%0t: unexpected result hrv %0d temp %0d level %0d",
                         $time, got.hrv_avg, got.temp_avg, got.level);
        end
        else
        begin
            due = expected_averages.pop_front();
            results_checked++;
            level_count[due.level]++;
            if (got.hrv_avg !== due.hrv_avg || got.temp_avg !== due.temp_avg ||
                got.level !== due.level)
            begin
                error_count++;
                if (error_count <= REPORT_LIMIT)
                    $display("%0t: result %0d expected hrv %0d temp %0d level %0d, got hrv %0d temp %0d level %0d",
                             $time, results_checked, due.hrv_avg, due.temp_avg, due.level,
                             got.hrv_avg, got.temp_avg, got.level);
            end
        end
    endtask

    // sample driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            sample_ch.valid <= 1'b0;
            offering = 1'b0;
            tx_wait  = 0;
        end
        else
        begin
            if (sample_ch.valid && sample_ch.ready)
            begin
                fold_into_window(sample_ch.hrv_sample, sample_ch.temp_sample);
                offering = 1'b0;
                tx_wait  = tx_gaps ? $urandom_range(0, MAX_GAP) : 0;
            end
            if (!offering)
            begin
                if (tx_wait > 0)
                    tx_wait--;
                else if (pending_vitals.size() != 0)
                begin
                    staged = pending_vitals.pop_front();
                    sample_ch.hrv_sample  <= staged.hrv;
                    sample_ch.temp_sample <= staged.temp;
                    offering = 1'b1;
                end
            end
            sample_ch.valid <= offering;
        end
    end

    // result monitor with random back-pressure and one long hold
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
            rx_wait = 0;
        end
        else
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                check_averages({result_ch.hrv_average, result_ch.temp_average,
                                result_ch.alert_level});
                rx_wait = rx_gaps ? $urandom_range(0, MAX_GAP) : 0;
            end
            else if (rx_wait > 0)
            begin
                rx_wait--;
            end
            if (long_stall_go && !long_stall_done)
            begin
                hold_left       = LONG_HOLD;
                long_stall_done = 1'b1;
            end
            else if (hold_left > 0)
            begin
                hold_left--;
            end
            result_ch.ready <= (rx_wait == 0) && (hold_left == 0);
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                     $time, idle_cycles, expected_averages.size());
            $display("windowed_average_alert_classifier: mismatch");
            $finish;
        end
    end

    // one register write, mirrored into the limit copies
    task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        case (idx)
            REG_HRV_CRITICAL:  hrv_crit_lim  = value[HRV_W-1:0];
            REG_HRV_WARNING:   hrv_warn_lim  = value[HRV_W-1:0];
            REG_TEMP_CRITICAL: temp_crit_lim = value[TEMP_W-1:0];
            REG_TEMP_WARNING:  temp_warn_lim = value[TEMP_W-1:0];
            default: ;
        endcase
        register_writes++;
    endtask

    task automatic write_limits(input int hrv_crit, input int hrv_warn,
                                input int temp_crit, input int temp_warn);
        write_register(REG_HRV_CRITICAL, CFG_DATA_W'(hrv_crit));
        write_register(REG_HRV_WARNING, CFG_DATA_W'(hrv_warn));
        write_register(REG_TEMP_CRITICAL, CFG_DATA_W'(temp_crit));
        write_register(REG_TEMP_WARNING, CFG_DATA_W'(temp_warn));
        settings_used++;
    endtask

    // hold off new samples until every result is back
    task automatic wait_drained();
        while (pending_vitals.size() != 0 || offering || expected_averages.size() != 0)
            @(negedge clk);
    endtask

    task automatic queue_sample(input int hrv, input int temp);
        pending_vitals.push_back({HRV_W'(hrv), TEMP_W'(temp)});
    endtask

    task automatic queue_uniform(input int count);
        repeat (count)
            queue_sample($urandom_range(0, HRV_TOP), $urandom_range(0, TEMP_TOP));
    endtask

    // run level chosen around the two limits so averages cross them
    function automatic int pick_level(input int lower, input int upper, input int top);
        int lo;
        int hi;
        lo = (lower < upper) ? lower : upper;
        hi = (lower < upper) ? upper : lower;
        case ($urandom_range(0, 7))
            0:       return 0;
            1, 2:    return lo * 3 / 4;
            3, 4:    return (lo + hi) / 2;
            5, 6:    return (hi * 5 / 4 + 20 > top) ? top : hi * 5 / 4 + 20;
            default: return top;
        endcase
    endfunction

    function automatic int jitter(input int center, input int spread, input int top);
        int v;
        v = center + int'($urandom_range(0, 2 * spread)) - spread;
        if (v < 0)
            v = 0;
        else if (v > top)
            v = top;
        return v;
    endfunction

    // runs of steady readings with noise, the occasional wild sample mixed in
    task automatic queue_regime(input int count);
        int hrv_left;
        int temp_left;
        int hrv_level;
        int temp_level;
        hrv_left   = 0;
        temp_left  = 0;
        hrv_level  = 0;
        temp_level = 0;
        repeat (count)
        begin
            if (hrv_left == 0)
            begin
                hrv_left  = $urandom_range(40, 150);
                hrv_level = pick_level(hrv_crit_lim, hrv_warn_lim, HRV_TOP);
            end
            if (temp_left == 0)
            begin
                temp_left  = $urandom_range(40, 150);
                temp_level = pick_level(temp_crit_lim, temp_warn_lim, TEMP_TOP);
            end
            if ($urandom_range(0, 19) == 0)
                queue_uniform(1);
            else
                queue_sample(jitter(hrv_level, 40, HRV_TOP), jitter(temp_level, 20, TEMP_TOP));
            hrv_left--;
            temp_left--;
        end
    endtask

    // phase sequencing
    initial
    begin
        int round;
        int hrv_crit;
        int hrv_warn;
        int temp_crit;
        int temp_warn;

        rst_n                 = 1'b0;
        sample_ch.valid       = 1'b0;
        sample_ch.hrv_sample  = '0;
        sample_ch.temp_sample = '0;
        result_ch.ready       = 1'b0;
        cfg_ch.valid          = 1'b0;
        cfg_ch.index          = '0;
        cfg_ch.data           = '0;
        write_pos             = 0;
        window_fill           = 0;
        hrv_sum               = 0;
        temp_sum              = 0;
        hrv_crit_lim          = HRV_CRITICAL_RESET;
        hrv_warn_lim          = HRV_WARNING_RESET;
        temp_crit_lim         = TEMP_CRITICAL_RESET;
        temp_warn_lim         = TEMP_WARNING_RESET;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // field extremes and values at the reset limits
        queue_sample(0, 0);
        queue_sample(HRV_TOP, TEMP_TOP);
        queue_sample(HRV_TOP, 10000);
        queue_sample(500, 3600);
        queue_sample(499, 3599);
        queue_sample(600, 3650);
        queue_sample(599, 3649);
        queue_sample(0, TEMP_TOP);
        queue_sample(HRV_TOP, 0);
        queue_sample(32768, 8192);
        queue_sample(1, 1);
        queue_sample(HRV_TOP - 1, TEMP_TOP - 1);
        queue_sample(16'h5555, 14'h1555);
        queue_sample(16'haaaa, 14'h2aaa);
        queue_sample(500, 3650);
        queue_sample(600, 3600);
        wait_drained();

        // fill the window past wrap with the largest samples, no idling
        tx_gaps = 1'b0;
        rx_gaps = 1'b0;
        repeat (WINDOW_DEPTH + 10) queue_sample(HRV_TOP, TEMP_TOP);
        wait_drained();

        // zero limits, stray indexes, long result hold while samples keep coming
        write_limits(0, 0, 0, 0);
        write_register(REG_FIRST_UNUSED, '1);
        write_register(REG_LAST_UNUSED, 16'h1234);
        tx_gaps = 1'b1;
        rx_gaps = 1'b1;
        queue_uniform(150);
        long_stall_go = 1'b1;
        wait_drained();

        // all-ones limits, temperature limits masked to their width
        write_limits(HRV_TOP, HRV_TOP, 16'hffff, 16'hffff);
        tx_gaps = 1'b0;
        queue_uniform(100);
        wait_drained();

        // random limits with readings drifting across them
        for (round = 0; round < 4; round++)
        begin
            hrv_crit  = $urandom_range(200, 3000);
            hrv_warn  = hrv_crit + $urandom_range(100, 1000);
            temp_crit = $urandom_range(3000, 3700);
            temp_warn = temp_crit + $urandom_range(20, 300);
            if (round == 2)
                write_limits(hrv_warn, hrv_crit, temp_warn, temp_crit);
            else
                write_limits(hrv_crit, hrv_warn, temp_crit, temp_warn);
            tx_gaps = (round != 0);
            rx_gaps = (round != 0) && (round != 3);
            queue_regime(175);
            wait_drained();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        $display("%0d results checked through a %0d-entry window, %0d register writes, %0d limit settings",
                 results_checked, WINDOW_DEPTH, register_writes, settings_used);
        $display("alert levels: optimal %0d, attention %0d, critical %0d",
                 level_count[ALERT_OPTIMAL], level_count[ALERT_ATTENTION],
                 level_count[ALERT_CRITICAL]);
        if (error_count == 0)
            $display("windowed_average_alert_classifier: match");
        else
            $display("windowed_average_alert_classifier: mismatch");
        $finish;
    end

endmodule
